// File: rtl/core/fbaps_pkg.sv
`default_nettype none
// ============================================================================
// Frequency band antenna port selector package
// Shared payload types, command codes and control byte constants.
// ============================================================================
package fbaps_pkg;

    typedef struct packed {
        logic        cmd;
        logic [15:0] range_low_mhz;
        logic [15:0] range_high_mhz;
        logic [7:0]  first_port;
        logic [15:0] tune_mhz;
    } t_in;

    typedef struct packed {
        logic       status;
        logic       write_valid;
        logic [6:0] device_address;
        logic [7:0] control_byte;
        logic [3:0] selected_index;
    } t_out;

    typedef struct packed {
        logic [15:0] range_low_mhz;
        logic [15:0] range_high_mhz;
        logic [7:0]  port_a;
        logic [7:0]  port_b;
    } t_entry;

    localparam logic       CmdAdd  = 1'b0;
    localparam logic       CmdTune = 1'b1;

    localparam logic [7:0] CtrlOutDisable = 8'h80;
    localparam logic [7:0] CtrlSameSide   = 8'h04;
    localparam logic [7:0] CtrlLedEn      = 8'h02;
    localparam logic [7:0] PortLast       = 8'd7;
    localparam logic [7:0] SideSplit      = 8'd4;
    localparam logic [6:0] BoardAddrReset = 7'd24;

    function automatic logic [7:0] switch_bits(input logic [7:0] port);
        logic [7:0] low2;
        low2 = {6'd0, port[1:0]};
        if (port < SideSplit) begin
            return low2 << 5;
        end
        return low2 << 3;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/fbaps_ram.sv
`default_nettype none
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ============================================================================
module fbaps_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: rtl/core/frequency_band_antenna_port_selector_core.sv
`default_nettype none
// ============================================================================
// Frequency band antenna port selector core
// Keeps a table of frequency bands with two antenna ports each and, on a tune
// command, selects the first matching band and builds the switch control byte.
// ============================================================================
//
//  Channel  Direction  Handshake              Payload
//  -------  ---------  ---------------------  ------------------------------
//  in       input      i_in_valid / o_in_stall    i_in_data   (t_in)
//  out      output     o_out_valid / i_out_stall  o_out_data  (t_out)
//  cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_data  (board address)
//
//  An add, or a tune of an empty table, goes straight to finish; a tune
//  else reads the entries one at a time through the single read port of
//  the entry RAM, evaluates, then finishes. One item is in work at a time.
//  After reset the table is empty, nothing is selected and the address is 24.
//  A stalled output holds its result; the next item may be taken meanwhile.
//
module frequency_band_antenna_port_selector_core
    import fbaps_pkg::*;
#(
    parameter int MAX_RANGES = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_in        i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_out            o_out_data,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [6:0] i_cfg_data
);

    localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam int EW = $bits(t_entry);
    localparam logic [CW-1:0] MaxCount = CW'(MAX_RANGES);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_CMP  = 5'b00100,
        S_EVAL = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_idx;
    logic [CW-1:0]   r_cur;
    logic            r_cur_valid;
    logic [6:0]      r_board_addr;
    logic [15:0]     r_tune;
    logic [7:0]      r_pa;
    logic [7:0]      r_pb;
    t_out            r_res;
    logic            r_out_valid;
    t_out            r_out_data;

    logic            n_accept;
    logic            n_add_we;
    t_entry          n_wentry;
    logic [EW-1:0]   n_rdata_raw;
    t_entry          n_rentry;
    logic            n_hit;
    logic [CW-1:0]   n_idx_inc;
    logic            n_out_free;
    logic            n_a_low;
    logic            n_b_low;
    logic            n_ports_ok;
    logic [7:0]      n_ctrl;
    logic            n_same_sel;
    t_out            n_tune_res;
    t_out            n_start_res;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign n_accept    = i_in_valid && !o_in_stall;
    assign n_add_we    = n_accept && (i_in_data.cmd == CmdAdd) && (r_count < MaxCount);
    assign n_out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_wentry.range_low_mhz  = i_in_data.range_low_mhz;
        n_wentry.range_high_mhz = i_in_data.range_high_mhz;
        n_wentry.port_a         = i_in_data.first_port;
        n_wentry.port_b         = (i_in_data.first_port < SideSplit)
                                  ? (8'(r_count) + SideSplit) : 8'd0;
    end

    always_comb begin
        n_start_res        = '0;
        n_start_res.status = (i_in_data.cmd == CmdAdd) ? (r_count >= MaxCount)
                                                       : (r_count == '0);
    end

    fbaps_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_RANGES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (n_add_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (n_wentry),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (n_rdata_raw)
    );

    assign n_rentry  = t_entry'(n_rdata_raw);
    assign n_hit     = (r_tune >= n_rentry.range_low_mhz) &&
                       (r_tune <= n_rentry.range_high_mhz);
    assign n_idx_inc = r_idx + CW'(1);

    always_comb begin
        n_a_low    = (r_pa < SideSplit);
        n_b_low    = (r_pb < SideSplit);
        n_ports_ok = (r_pa <= PortLast) && (r_pb <= PortLast) &&
                     !((n_a_low == n_b_low) && !((r_pa == 8'd0) && (r_pb == 8'd0)));
        n_ctrl     = CtrlOutDisable | (n_a_low ? CtrlSameSide : 8'd0) |
                     switch_bits(r_pa) | switch_bits(r_pb) | CtrlLedEn;
        n_same_sel = r_cur_valid && (r_cur == r_idx);

        n_tune_res                = '0;
        n_tune_res.selected_index = 4'(r_idx);
        if (n_same_sel) begin
            n_tune_res.status = 1'b1;
        end else if (n_ports_ok) begin
            n_tune_res.write_valid    = 1'b1;
            n_tune_res.device_address = r_board_addr;
            n_tune_res.control_byte   = n_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_cur        <= '0;
            r_cur_valid  <= 1'b0;
            r_board_addr <= BoardAddrReset;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_board_addr <= i_cfg_data;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_res  <= n_start_res;
                        r_tune <= i_in_data.tune_mhz;
                        r_idx  <= '0;
                        if (i_in_data.cmd == CmdAdd) begin
                            if (r_count < MaxCount) begin
                                r_count <= r_count + CW'(1);
                            end
                            r_state <= S_FIN;
                        end else if (r_count == '0) begin
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (n_hit) begin
                        r_pa    <= n_rentry.port_a;
                        r_pb    <= n_rentry.port_b;
                        r_state <= S_EVAL;
                    end else if (n_idx_inc == r_count) begin
                        r_pa    <= 8'd0;
                        r_pb    <= 8'd0;
                        r_idx   <= n_idx_inc;
                        r_state <= S_EVAL;
                    end else begin
                        r_idx   <= n_idx_inc;
                        r_state <= S_READ;
                    end
                end
                S_EVAL: begin
                    r_res <= n_tune_res;
                    if (!n_same_sel) begin
                        r_cur       <= r_idx;
                        r_cur_valid <= 1'b1;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (n_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if ((r_state == S_FIN) && n_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FIN) && n_out_free) begin
            r_out_data <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MaxCount)
        else $error("entry count exceeds table depth");

    a_scan_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_idx < r_count))
        else $error("scan index outside stored entries");

    a_write_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.write_valid && o_out_data.status))
        else $error("control byte issued with error status");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_FIN))
        else $error("result presented without finishing an item");

    a_cur_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> (r_cur <= r_count))
        else $error("current selection beyond entry count");

endmodule
`default_nettype wire
